@@ hw/rtl/cet_pkg.sv @@
package cet_pkg;

    localparam int ID_W            = 32;
    localparam int KEY_W           = 2 * ID_W;
    localparam int VEC_W           = 48;
    localparam int PAIR_SLOTS_DEF  = 256;
    localparam int COORD_BITS_DEF  = 16;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_ENTER = 2'd1,
        EV_STAY  = 2'd2,
        EV_EXIT  = 2'd3
    } t_event;

    // query travelling down the cell chain
    typedef struct packed {
        logic             vld;
        logic [KEY_W-1:0] key;
        logic             ovl;
        logic             own;
        logic             done;
        t_event           evt;
    } t_token;

    typedef struct packed {
        t_event evt;
        logic   touch;
    } t_resolve;

    function automatic t_resolve resolve_contact(input logic touch, input logic ovl,
                                                 input logic own);
        t_resolve r;
        r.evt   = EV_NONE;
        r.touch = touch;
        if (ovl) begin
            if (touch) begin
                if (own) begin
                    r.evt = EV_STAY;
                end else begin
                    r.evt   = EV_EXIT;
                    r.touch = 1'b0;
                end
            end else if (own) begin
                r.evt   = EV_ENTER;
                r.touch = 1'b1;
            end
        end else if (touch) begin
            r.evt   = EV_EXIT;
            r.touch = 1'b0;
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/cet_if.sv @@
interface cet_in_if;
    logic                      valid;
    logic                      ready;
    logic [cet_pkg::ID_W-1:0]  left_id;
    logic [cet_pkg::ID_W-1:0]  right_id;
    logic [cet_pkg::VEC_W-1:0] left_center;
    logic [cet_pkg::VEC_W-1:0] left_extent;
    logic [cet_pkg::VEC_W-1:0] right_center;
    logic [cet_pkg::VEC_W-1:0] right_extent;
    logic                      left_enabled;
    logic                      right_enabled;
    logic                      left_owner_live;
    logic                      right_owner_live;

    modport source (
        output valid, left_id, right_id, left_center, left_extent, right_center,
               right_extent, left_enabled, right_enabled, left_owner_live,
               right_owner_live,
        input  ready
    );
    modport sink (
        input  valid, left_id, right_id, left_center, left_extent, right_center,
               right_extent, left_enabled, right_enabled, left_owner_live,
               right_owner_live,
        output ready
    );
endinterface

interface cet_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] contact_event;
    logic       boxes_overlap;
    logic       table_full;

    modport source (output valid, contact_event, boxes_overlap, table_full, input ready);
    modport sink   (input valid, contact_event, boxes_overlap, table_full, output ready);
endinterface

@@ hw/rtl/cet_front.sv @@
module cet_front #(
    parameter int COORD_BITS = cet_pkg::COORD_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    cet_in_if.sink          i_pair,
    output cet_pkg::t_token o_tok
);
    import cet_pkg::*;

    localparam int EXT_W = 64;

    logic [EXT_W-1:0] w_lc, w_le, w_rc, w_re;
    logic [2:0]       w_axis_hit;
    t_token           n_tok, r_tok;

    assign i_pair.ready = i_adv;

    assign w_lc = {{(EXT_W-VEC_W){1'b0}}, i_pair.left_center};
    assign w_le = {{(EXT_W-VEC_W){1'b0}}, i_pair.left_extent};
    assign w_rc = {{(EXT_W-VEC_W){1'b0}}, i_pair.right_center};
    assign w_re = {{(EXT_W-VEC_W){1'b0}}, i_pair.right_extent};

    // per axis: 2*|rc-lc| < le+re
    for (genvar k = 0; k < 3; k++) begin : g_axis
        logic signed [COORD_BITS:0] w_d;
        logic        [COORD_BITS:0] w_ad;
        logic        [COORD_BITS+1:0] w_twice;
        logic        [COORD_BITS+1:0] w_span;

        assign w_d = $signed({w_rc[k*COORD_BITS+COORD_BITS-1], w_rc[k*COORD_BITS +: COORD_BITS]})
                   - $signed({w_lc[k*COORD_BITS+COORD_BITS-1], w_lc[k*COORD_BITS +: COORD_BITS]});
        assign w_ad    = w_d[COORD_BITS] ? (COORD_BITS+1)'(0) - w_d : w_d;
        assign w_twice = {w_ad, 1'b0};
        assign w_span  = {2'b00, w_le[k*COORD_BITS +: COORD_BITS]}
                       + {2'b00, w_re[k*COORD_BITS +: COORD_BITS]};
        assign w_axis_hit[k] = w_twice < w_span;
    end

    always_comb begin
        n_tok      = '0;
        n_tok.vld  = i_pair.valid;
        n_tok.key  = {i_pair.left_id, i_pair.right_id};
        n_tok.own  = i_pair.left_owner_live & i_pair.right_owner_live;
        n_tok.evt  = EV_NONE;
        if (!i_pair.left_enabled || !i_pair.right_enabled
            || i_pair.left_id == i_pair.right_id) begin
            // skipped pair rides the chain as already resolved
            n_tok.done = 1'b1;
            n_tok.ovl  = 1'b0;
        end else begin
            n_tok.done = 1'b0;
            n_tok.ovl  = &w_axis_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else if (i_adv) begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

@@ hw/rtl/cet_cell.sv @@
module cet_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  cet_pkg::t_token i_tok,
    output cet_pkg::t_token o_tok
);
    import cet_pkg::*;

    logic             r_valid, n_valid;
    logic [KEY_W-1:0] r_key, n_key;
    logic             r_touch, n_touch;
    t_token           r_tok, n_tok;

    always_comb begin
        t_resolve res;
        res     = '0;
        n_tok   = i_tok;
        n_valid = r_valid;
        n_key   = r_key;
        n_touch = r_touch;
        if (i_tok.vld && !i_tok.done) begin
            if (!r_valid) begin
                // first free cell claims the new pair
                res        = resolve_contact(1'b0, i_tok.ovl, i_tok.own);
                n_valid    = 1'b1;
                n_key      = i_tok.key;
                n_touch    = res.touch;
                n_tok.done = 1'b1;
                n_tok.evt  = res.evt;
            end else if (r_key == i_tok.key) begin
                res        = resolve_contact(r_touch, i_tok.ovl, i_tok.own);
                n_touch    = res.touch;
                n_tok.done = 1'b1;
                n_tok.evt  = res.evt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_touch <= 1'b0;
            r_tok   <= '0;
        end else if (i_adv) begin
            r_valid <= n_valid;
            r_touch <= n_touch;
            r_tok   <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_key <= n_key;
        end
    end

    assign o_tok = r_tok;

endmodule

@@ hw/rtl/aabb_contact_event_tracker.sv @@
// channel   | dir | modport           | payload
// i_pair    | in  | cet_in_if.sink    | ids, centers, extents, enable and owner flags
// o_event   | out | cet_out_if.source | contact_event, boxes_overlap, table_full
//
// one pair per cycle sustained while o_event does not stall; the query walks the
// cell chain one cell per cycle (front stage, cells, output reg)
// cells fill in order, so no clearing pass; reset empties the table at once
// a stall on o_event freezes the whole chain; i_pair.ready follows it
module aabb_contact_event_tracker #(
    parameter int PAIR_SLOTS = cet_pkg::PAIR_SLOTS_DEF,
    parameter int COORD_BITS = cet_pkg::COORD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cet_in_if.sink    i_pair,
    cet_out_if.source o_event
);
    import cet_pkg::*;

    logic     w_adv;
    t_token   w_tok [PAIR_SLOTS+1];
    t_token   w_last;
    t_resolve w_miss;
    logic     r_out_valid;
    t_event   r_evt, n_evt;
    logic     r_ovl, n_ovl;
    logic     r_full, n_full;

    assign w_adv = !r_out_valid || o_event.ready;

    cet_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_pair  (i_pair),
        .o_tok   (w_tok[0])
    );

    for (genvar i = 0; i < PAIR_SLOTS; i++) begin : g_cell
        cet_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_tok   (w_tok[i]),
            .o_tok   (w_tok[i+1])
        );
    end

    assign w_last = w_tok[PAIR_SLOTS];
    assign w_miss = resolve_contact(1'b0, w_last.ovl, w_last.own);

    // a query that found no cell means the table is full
    always_comb begin
        n_ovl = w_last.ovl;
        if (w_last.done) begin
            n_evt  = w_last.evt;
            n_full = 1'b0;
        end else begin
            n_evt  = w_miss.evt;
            n_full = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_last.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_evt  <= n_evt;
            r_ovl  <= n_ovl;
            r_full <= n_full;
        end
    end

    assign o_event.valid         = r_out_valid;
    assign o_event.contact_event = r_evt;
    assign o_event.boxes_overlap = r_ovl;
    assign o_event.table_full    = r_full;

endmodule
